>>> design/idmcc_pkg.sv
// Shared types and constants for the interval min-cut-cost block.
// No dependencies; used by idmcc_ctrl, idmcc_dp and interval_dp_min_cut_cost.
package idmcc_pkg;

  localparam int MAX_CUTS_DEF = 64;
  localparam int POS_BITS_DEF = 20;
  localparam int COST_W       = 27;

  typedef logic [4:0] op_t;

  // Datapath operations issued by the controller
  localparam op_t OP_NONE = 5'd0;
  localparam op_t OP_LOAD = 5'd1;
  localparam op_t OP_BND0 = 5'd2;
  localparam op_t OP_BND1 = 5'd3;
  localparam op_t OP_SA   = 5'd4;
  localparam op_t OP_SV   = 5'd5;
  localparam op_t OP_SC   = 5'd6;
  localparam op_t OP_SW   = 5'd7;
  localparam op_t OP_ZI   = 5'd8;
  localparam op_t OP_L0   = 5'd9;
  localparam op_t OP_SPAN = 5'd10;
  localparam op_t OP_SEG  = 5'd11;
  localparam op_t OP_KC   = 5'd12;
  localparam op_t OP_WR   = 5'd13;
  localparam op_t OP_NL   = 5'd14;
  localparam op_t OP_RES  = 5'd15;
  localparam op_t OP_OUT  = 5'd16;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic gt;         // stored neighbor larger than the value being inserted
    logic b_one;      // insertion slot is at index one
    logic a_last;     // last element of the sort pass
    logic i_last;     // last unit span cleared
    logic k_last;     // last split point of the span
    logic span_last;  // last span of the current length
    logic len_done;   // all span lengths done
    logic out_busy;   // result register still holds an untaken word
  } status_t;

endpackage

>>> design/idmcc_ctrl.sv
// Controller state machine for the interval min-cut-cost block.
// Depends on idmcc_pkg; drives idmcc_dp through cmd_t, reads status_t.
module idmcc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              last_cut,
  input  idmcc_pkg::status_t st,
  output idmcc_pkg::cmd_t   cmd,
  output logic              in_stall
);

  localparam logic [3:0] ST_LOAD = 4'd0;
  localparam logic [3:0] ST_BND0 = 4'd1;
  localparam logic [3:0] ST_BND1 = 4'd2;
  localparam logic [3:0] ST_SA   = 4'd3;
  localparam logic [3:0] ST_SV   = 4'd4;
  localparam logic [3:0] ST_SC   = 4'd5;
  localparam logic [3:0] ST_SW   = 4'd6;
  localparam logic [3:0] ST_ZI   = 4'd7;
  localparam logic [3:0] ST_L0   = 4'd8;
  localparam logic [3:0] ST_SPAN = 4'd9;
  localparam logic [3:0] ST_SEG  = 4'd10;
  localparam logic [3:0] ST_KC   = 4'd11;
  localparam logic [3:0] ST_WR   = 4'd12;
  localparam logic [3:0] ST_NL   = 4'd13;
  localparam logic [3:0] ST_RES  = 4'd14;
  localparam logic [3:0] ST_OUT  = 4'd15;

  logic [3:0] state, state_next;

  assign in_stall = (state != ST_LOAD);

  // Sequence: load, boundaries, insertion sort, clear unit spans, fill table, result
  always_comb begin
    state_next = state;
    cmd.op     = idmcc_pkg::OP_NONE;
    unique case (state)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.op = idmcc_pkg::OP_LOAD;
          if (last_cut) state_next = ST_BND0;
        end
      end
      ST_BND0: begin
        cmd.op = idmcc_pkg::OP_BND0;
        state_next = ST_BND1;
      end
      ST_BND1: begin
        cmd.op = idmcc_pkg::OP_BND1;
        state_next = ST_SA;
      end
      ST_SA: begin
        cmd.op = idmcc_pkg::OP_SA;
        state_next = ST_SV;
      end
      ST_SV: begin
        cmd.op = idmcc_pkg::OP_SV;
        state_next = ST_SC;
      end
      ST_SC: begin
        cmd.op = idmcc_pkg::OP_SC;
        if (!(st.gt && !st.b_one)) state_next = ST_SW;
      end
      ST_SW: begin
        cmd.op = idmcc_pkg::OP_SW;
        state_next = st.a_last ? ST_ZI : ST_SA;
      end
      ST_ZI: begin
        cmd.op = idmcc_pkg::OP_ZI;
        if (st.i_last) state_next = ST_L0;
      end
      ST_L0: begin
        cmd.op = idmcc_pkg::OP_L0;
        state_next = ST_SPAN;
      end
      ST_SPAN: begin
        cmd.op = idmcc_pkg::OP_SPAN;
        state_next = ST_SEG;
      end
      ST_SEG: begin
        cmd.op = idmcc_pkg::OP_SEG;
        state_next = ST_KC;
      end
      ST_KC: begin
        cmd.op = idmcc_pkg::OP_KC;
        if (st.k_last) state_next = ST_WR;
      end
      ST_WR: begin
        cmd.op = idmcc_pkg::OP_WR;
        state_next = st.span_last ? ST_NL : ST_SPAN;
      end
      ST_NL: begin
        cmd.op = idmcc_pkg::OP_NL;
        state_next = st.len_done ? ST_RES : ST_SPAN;
      end
      ST_RES: begin
        // hold until the previous result word is taken
        if (!st.out_busy) begin
          cmd.op = idmcc_pkg::OP_RES;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd.op = idmcc_pkg::OP_OUT;
        state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

endmodule

>>> design/idmcc_dp.sv
// Datapath for the interval min-cut-cost block: position and cost memories,
// counters, adder/compare and result register. Depends on idmcc_pkg.
module idmcc_dp #(
  parameter int MAX_CUTS = idmcc_pkg::MAX_CUTS_DEF,
  parameter int POS_BITS = idmcc_pkg::POS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  idmcc_pkg::cmd_t               cmd,
  input  logic [POS_BITS-1:0]           cut_position,
  input  logic [POS_BITS-1:0]           stick_length,
  input  logic                          last_cut,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [idmcc_pkg::COST_W-1:0]  min_cost,
  output logic                          overflow,
  output idmcc_pkg::status_t            st
);

  localparam int NPOS  = MAX_CUTS + 2;
  localparam int AW    = $clog2(NPOS);
  localparam int TW    = $clog2(NPOS + 1);
  localparam int CNTW  = $clog2(MAX_CUTS + 1);
  localparam int CAW   = $clog2(NPOS * NPOS);
  localparam int CW    = idmcc_pkg::COST_W;
  localparam int SUM_W = ((POS_BITS > CW) ? POS_BITS : CW) + 2;

  localparam logic [CW-1:0] COST_MAX = {CW{1'b1}};

  logic [POS_BITS-1:0] pos_mem [NPOS];
  logic [CW-1:0]       cost_mem [NPOS*NPOS];

  logic [CNTW-1:0]     cnt;
  logic                too_many;
  logic [POS_BITS-1:0] stick;
  logic [TW-1:0]       total, a, b, i, j, len, kleft;
  logic [POS_BITS-1:0] v, seg;
  logic [CAW-1:0]      zi_addr, base_i, addr_ik, addr_kj;
  logic [SUM_W-1:0]    best;

  // memory ports
  logic                pw_en;
  logic [TW-1:0]       pw_addr, pr0_addr, pr1_addr;
  logic [POS_BITS-1:0] pw_data, prd0, prd1;
  logic                cw_en;
  logic [CAW-1:0]      cw_addr, cr0_addr, cr1_addr;
  logic [CW-1:0]       cw_data, crd0, crd1;
  logic [SUM_W-1:0]    sum;
  logic                out_take;

  assign out_take = out_valid && !out_stall;
  assign sum = SUM_W'(seg) + SUM_W'(crd0) + SUM_W'(crd1);

  // Decode the command into memory port controls
  always_comb begin
    pw_en    = 1'b0;
    pw_addr  = b;
    pw_data  = v;
    pr0_addr = a;
    pr1_addr = j;
    cw_en    = 1'b0;
    cw_addr  = zi_addr;
    cw_data  = '0;
    cr0_addr = addr_ik;
    cr1_addr = addr_kj;
    unique case (cmd.op)
      idmcc_pkg::OP_LOAD: begin
        pw_en   = (cnt < CNTW'(MAX_CUTS));
        pw_addr = TW'(cnt);
        pw_data = cut_position;
      end
      idmcc_pkg::OP_BND0: begin
        pw_en   = 1'b1;
        pw_addr = TW'(cnt);
        pw_data = '0;
      end
      idmcc_pkg::OP_BND1: begin
        pw_en   = 1'b1;
        pw_addr = TW'(cnt) + TW'(1);
        pw_data = stick;
      end
      idmcc_pkg::OP_SA:   pr0_addr = a;
      idmcc_pkg::OP_SV:   pr0_addr = a - TW'(1);
      idmcc_pkg::OP_SC: begin
        pr0_addr = b - TW'(2);
        pw_en    = (prd0 > v);
        pw_data  = prd0;
      end
      idmcc_pkg::OP_SW:   pw_en = 1'b1;
      idmcc_pkg::OP_ZI:   cw_en = 1'b1;
      idmcc_pkg::OP_SPAN: pr0_addr = i;
      idmcc_pkg::OP_WR: begin
        cw_en   = 1'b1;
        cw_addr = base_i + CAW'(j);
        cw_data = (best > SUM_W'(COST_MAX)) ? COST_MAX : best[CW-1:0];
      end
      idmcc_pkg::OP_RES:  cr0_addr = CAW'(total) - CAW'(1);
      default: ;
    endcase
  end

  // Position memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (pw_en) pos_mem[pw_addr[AW-1:0]] <= pw_data;
    prd0 <= pos_mem[pr0_addr[AW-1:0]];
    prd1 <= pos_mem[pr1_addr[AW-1:0]];
  end

  // Cost table: one write, two registered reads
  always_ff @(posedge clk) begin
    if (cw_en) cost_mem[cw_addr] <= cw_data;
    crd0 <= cost_mem[cr0_addr];
    crd1 <= cost_mem[cr1_addr];
  end

  // Control counters and result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      too_many  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == idmcc_pkg::OP_OUT) out_valid <= 1'b1;
      else if (out_take)               out_valid <= 1'b0;
      unique case (cmd.op)
        idmcc_pkg::OP_LOAD: begin
          if (cnt < CNTW'(MAX_CUTS)) cnt <= cnt + CNTW'(1);
          else                       too_many <= 1'b1;
        end
        idmcc_pkg::OP_OUT: begin
          cnt       <= '0;
          too_many  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Loop indexes, addresses and the running minimum
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      idmcc_pkg::OP_LOAD: if (last_cut) stick <= stick_length;
      idmcc_pkg::OP_BND1: begin
        total   <= TW'(cnt) + TW'(2);
        a       <= TW'(1);
        i       <= '0;
        zi_addr <= CAW'(1);
      end
      idmcc_pkg::OP_SV: begin
        v <= prd0;
        b <= a;
      end
      idmcc_pkg::OP_SC: if (prd0 > v) b <= b - TW'(1);
      idmcc_pkg::OP_SW: a <= a + TW'(1);
      idmcc_pkg::OP_ZI: begin
        i       <= i + TW'(1);
        zi_addr <= zi_addr + CAW'(NPOS + 1);
      end
      idmcc_pkg::OP_L0: begin
        len    <= TW'(2);
        i      <= '0;
        j      <= TW'(2);
        base_i <= '0;
      end
      idmcc_pkg::OP_SPAN: begin
        addr_ik <= base_i + CAW'(i) + CAW'(1);
        addr_kj <= base_i + CAW'(NPOS) + CAW'(j);
        best    <= '1;
        kleft   <= len - TW'(1);
      end
      idmcc_pkg::OP_SEG: begin
        seg     <= prd1 - prd0;
        addr_ik <= addr_ik + CAW'(1);
        addr_kj <= addr_kj + CAW'(NPOS);
      end
      idmcc_pkg::OP_KC: begin
        if (sum < best) best <= sum;
        addr_ik <= addr_ik + CAW'(1);
        addr_kj <= addr_kj + CAW'(NPOS);
        kleft   <= kleft - TW'(1);
      end
      idmcc_pkg::OP_WR: begin
        i      <= i + TW'(1);
        j      <= j + TW'(1);
        base_i <= base_i + CAW'(NPOS);
      end
      idmcc_pkg::OP_NL: begin
        len    <= len + TW'(1);
        i      <= '0;
        j      <= len + TW'(1);
        base_i <= '0;
      end
      default: ;
    endcase
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (cmd.op == idmcc_pkg::OP_OUT) begin
      min_cost <= crd0;
      overflow <= too_many;
    end
  end

  // Status back to the controller
  always_comb begin
    st.gt        = (prd0 > v);
    st.b_one     = (b == TW'(1));
    st.a_last    = (a == total - TW'(1));
    st.i_last    = (i == total - TW'(2));
    st.k_last    = (kleft == TW'(1));
    st.span_last = (j == total - TW'(1));
    st.len_done  = (len + TW'(1) == total);
    st.out_busy  = out_valid && !out_take;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNTW'(MAX_CUTS))
    else $error("cut count beyond capacity");

  a_out_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.op == idmcc_pkg::OP_OUT |=> cnt == '0 && !too_many && out_valid)
    else $error("set state not cleared after result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == idmcc_pkg::OP_OUT |-> !out_valid || out_take)
    else $error("result overwritten before taken");

endmodule

>>> design/interval_dp_min_cut_cost.sv
// Minimum cost to cut a stick: loads cuts, insertion-sorts them, fills an interval cost table.
// While loading it takes one cut per cycle. After the last cut it writes the two boundary
// positions, insertion-sorts, clears the unit spans, fills the table with a single split-point
// adder/compare and registers the result.
// A new set is accepted only after the result word is registered, which waits while the
// previous word is stalled. rst (synchronous) clears the controller, cut count, pending
// overflow flag and output valid; memories and the result word are not cleared.
module interval_dp_min_cut_cost #(
  parameter int MAX_CUTS = idmcc_pkg::MAX_CUTS_DEF,
  parameter int POS_BITS = idmcc_pkg::POS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [POS_BITS-1:0]           cut_position,
  input  logic [POS_BITS-1:0]           stick_length,
  input  logic                          last_cut,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [idmcc_pkg::COST_W-1:0]  min_cost,
  output logic                          overflow
);

  idmcc_pkg::cmd_t    cmd;
  idmcc_pkg::status_t st;

  idmcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last_cut (last_cut),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  idmcc_dp #(
    .MAX_CUTS (MAX_CUTS),
    .POS_BITS (POS_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cut_position (cut_position),
    .stick_length (stick_length),
    .last_cut     (last_cut),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .min_cost     (min_cost),
    .overflow     (overflow),
    .st           (st)
  );

endmodule

>>> test/interval_dp_min_cut_cost_tb.sv
// Self-checking testbench for interval_dp_min_cut_cost: drives cut sets, predicts the
// minimum cutting cost per set and compares every result word. Depends on idmcc_pkg and the RTL.

class cut_cost_scoreboard;
  localparam int MAXC = idmcc_pkg::MAX_CUTS_DEF;
  localparam int NP = MAXC + 2;
  localparam int CW = idmcc_pkg::COST_W;

  logic [19:0] cut_store[NP];
  int unsigned cut_cnt;
  bit too_many_cuts;
  logic [CW-1:0] cost_q[$];
  bit ovf_q[$];
  int errors;

  function new();
    cut_cnt = 0;
    too_many_cuts = 0;
    errors = 0;
  endfunction

  // Store one cut word; on the closing word, sort and fill the span cost table.
  function void note_cut(logic [19:0] pos, logic [19:0] len, bit last);
    longint unsigned span_tab[NP][NP];
    longint unsigned best, c, v;
    int total, a, b, i, j, k, sl;
    if (cut_cnt < MAXC) begin
      cut_store[cut_cnt] = pos;
      cut_cnt++;
    end else begin
      too_many_cuts = 1;
    end
    if (!last) return;
    total = cut_cnt + 2;
    cut_store[cut_cnt] = '0;
    cut_store[cut_cnt + 1] = len;
    for (a = 1; a < total; a++) begin
      v = cut_store[a];
      b = a;
      while (b > 0 && cut_store[b - 1] > v) begin
        cut_store[b] = cut_store[b - 1];
        b--;
      end
      cut_store[b] = v[19:0];
    end
    for (i = 0; i + 1 < total; i++) span_tab[i][i + 1] = 0;
    for (sl = 2; sl < total; sl++) begin
      for (i = 0; i + sl < total; i++) begin
        j = i + sl;
        best = '1;
        for (k = i + 1; k < j; k++) begin
          c = (cut_store[j] - cut_store[i]) + span_tab[i][k] + span_tab[k][j];
          if (c < best) best = c;
        end
        span_tab[i][j] = best;
      end
    end
    best = span_tab[0][total - 1];
    if (best > 64'h7FF_FFFF) best = 64'h7FF_FFFF;
    cost_q = {cost_q, best[CW-1:0]};
    ovf_q = {ovf_q, too_many_cuts};
    cut_cnt = 0;
    too_many_cuts = 0;
  endfunction

  function void check_cost(logic [CW-1:0] cost, logic ovf);
    logic [CW-1:0] exp_cost;
    bit exp_ovf;
    if (cost_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result word: cost %0d overflow %0d", cost, ovf);
      return;
    end
    exp_cost = cost_q.pop_front();
    exp_ovf = ovf_q.pop_front();
    if (cost !== exp_cost || ovf !== exp_ovf) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: cost exp %0d got %0d, overflow exp %0d got %0d",
                 exp_cost, cost, exp_ovf, ovf);
    end
  endfunction

  function int pending();
    return cost_q.size();
  endfunction
endclass

module interval_dp_min_cut_cost_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [19:0] cut_position, stick_length;
  logic last_cut;
  logic out_valid, out_stall;
  logic [26:0] min_cost;
  logic overflow;

  cut_cost_scoreboard sb;
  bit calm;
  bit stim_done;
  int sent;

  interval_dp_min_cut_cost dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cut_position(cut_position), .stick_length(stick_length), .last_cut(last_cut),
    .out_valid(out_valid), .out_stall(out_stall),
    .min_cost(min_cost), .overflow(overflow)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Check every accepted result word at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_cost(min_cost, overflow);
  end

  // Receiver stalls in random bursts until the quiet tail.
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  // Send one word, with an optional random gap, and hold it until accepted.
  task automatic send_cut(logic [19:0] pos, logic [19:0] len, bit last);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    cut_position <= pos;
    stick_length <= len;
    last_cut <= last;
    do @(posedge clk); while (in_stall);
    sb.note_cut(pos, len, last);
    sent++;
    @(negedge clk);
  endtask

  // Send a full set of n cuts; positions mostly inside the stick.
  task automatic send_set(int n, logic [19:0] len, bit wild);
    logic [19:0] p;
    for (int i = 0; i < n; i++) begin
      if (wild || len < 2) p = 20'($urandom);
      else p = 20'($urandom_range(1, len - 1));
      send_cut(p, len, i == n - 1);
    end
  endtask

  initial begin
    int n;
    logic [19:0] len;
    sb = new();
    calm = 0;
    stim_done = 0;
    sent = 0;
    rst = 1;
    in_valid = 0;
    cut_position = '0;
    stick_length = '0;
    last_cut = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: single cut, extremes, outside cuts, duplicates, zero length, overflow.
    send_cut(20'd3, 20'd7, 1);
    send_cut(20'hFFFFF, 20'hFFFFF, 1);
    send_cut(20'd0, 20'd0, 1);
    send_cut(20'd5, 20'd10, 0);
    send_cut(20'd5, 20'd10, 0);
    send_cut(20'd0, 20'd10, 0);
    send_cut(20'd10, 20'd10, 0);
    send_cut(20'd900, 20'd10, 1);
    send_cut(20'h55555, 20'hAAAAA, 0);
    send_cut(20'hAAAAA, 20'h55555, 1);
    send_set(64, 20'hFFFFF, 0);
    send_set(66, 20'd1000, 0);

    // Random sets: mostly small, a few at or over the cut limit.
    while (sent < 1650) begin
      case ($urandom_range(0, 19))
        0: n = $urandom_range(60, 70);
        1, 2: n = $urandom_range(20, 40);
        default: n = $urandom_range(1, 12);
      endcase
      len = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(1, 200));
      send_set(n, len, $urandom_range(0, 7) == 0);
    end
    // Quiet tail with no idling on either side.
    calm = 1;
    while (sent < 1750) send_set($urandom_range(1, 10), 20'($urandom_range(1, 5000)), 0);
    in_valid <= 0;
    stim_done = 1;
  end

  // Wait for all results to drain, then report.
  initial begin
    wait (stim_done);
    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end
endmodule
